/* src/pdgc_pkg.sv */
// Shared types and constants for the PD GoodCRC and transmit resolver.
`default_nettype none

package pdgc_pkg;

	localparam int RING_DEPTH = 8;

	localparam logic [4:0] MSG_GOODCRC = 5'd1;
	localparam logic [7:0] MIN_FRAME_BYTES = 8'd2;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	localparam logic [7:0] RST_TX_WATCH = 8'd3;
	localparam logic [7:0] RST_SINK_OK_IDLE = 8'd10;
	localparam logic [7:0] RST_MAX_FRAME = 8'd30;
	localparam logic [7:0] RST_MAX_PAYLOAD = 8'd28;

	typedef enum logic [1:0] {
		CFG_TX_WATCH     = 2'd0,
		CFG_SINK_OK_IDLE = 2'd1,
		CFG_MAX_FRAME    = 2'd2,
		CFG_MAX_PAYLOAD  = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		ACT_RX_FRAME  = 4'd0,
		ACT_TX_DONE   = 4'd1,
		ACT_HR_DONE   = 4'd2,
		ACT_HR_RX     = 4'd3,
		ACT_TICK      = 4'd4,
		ACT_TRANSMIT  = 4'd5,
		ACT_FETCH     = 4'd6,
		ACT_RX_ENABLE = 4'd7,
		ACT_ATTACH    = 4'd8,
		ACT_DETACH    = 4'd9,
		ACT_HR_SEND   = 4'd10
	} action_t;

	typedef enum logic [2:0] {
		TX_UNSET    = 3'd0,
		TX_ENQUEUED = 3'd1,
		TX_SENDING  = 3'd2,
		TX_SUCCESS  = 3'd3,
		TX_FAIL     = 3'd4
	} tx_state_t;

	typedef enum logic [1:0] {
		ORG_NONE    = 2'd0,
		ORG_GOODCRC = 2'd1,
		ORG_DATA    = 2'd2
	} tx_origin_t;

endpackage

`default_nettype wire

/* src/pdgc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pdgc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/pd_goodcrc_tx_resolver.sv */
// Top level of the PD sink GoodCRC and transmit resolver.
// The result transaction of an accepted input transaction is registered and appears in the cycle after it is accepted.
// Throughput: one transaction per cycle while results are taken; the result register frees itself when taken.
// The receive ring is one RAM whose registered read port feeds the fetched fields.
// Reset returns all control state to its reset values (receive enabled) and loads the register defaults at once.
// Ring contents are not cleared; an entry is always written before it is fetched.
`default_nettype none

module pd_goodcrc_tx_resolver #(
	parameter int RING_DEPTH = pdgc_pkg::RING_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  action,
	input  wire logic [15:0] header,
	input  wire logic [7:0]  frame_len,
	input  wire logic [2:0]  sop_kind,
	input  wire logic        status_fail,
	input  wire logic        wire_busy,
	input  wire logic        send_accepted,
	input  wire logic        enable,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             send_goodcrc,
	output logic      [15:0] goodcrc_header,
	output logic             send_data,
	output logic             send_hard_reset,
	output logic      [2:0]  tx_status,
	output logic             sink_tx_ok,
	output logic             rx_valid,
	output logic      [15:0] rx_header_out,
	output logic      [7:0]  rx_len_out,
	output logic             notify_hard_reset,
	output logic             wake
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

	logic [7:0] tx_watch_q, sink_idle_q, max_frame_q, max_payload_q;

	logic [AW-1:0]          head_q, tail_q;
	pdgc_pkg::tx_origin_t   origin_q;
	pdgc_pkg::tx_state_t    state_q;
	logic [2:0]             msg_id_q;
	logic                   gc_pend_q;
	logic [15:0]            gc_pend_hdr_q;
	logic                   rx_en_q;
	logic                   attached_q;
	logic                   sink_ok_q;
	logic [7:0]             watch_q;
	logic [7:0]             sink_cnt_q;

	logic [AW-1:0]          n_head, n_tail, ring_next;
	pdgc_pkg::tx_origin_t   n_origin;
	pdgc_pkg::tx_state_t    n_state;
	logic [2:0]             n_msg_id;
	logic                   n_gc_pend;
	logic [15:0]            n_gc_pend_hdr;
	logic                   n_rx_en;
	logic                   n_attached;
	logic                   n_sink_ok;
	logic [7:0]             n_watch;
	logic [7:0]             n_sink_cnt;

	logic        attempted, known, ring_we, ring_re;
	logic        o_gc, o_data, o_hr, o_wake, o_rxv, o_notify;
	logic [15:0] o_gc_hdr, gc_hdr, arm_hdr;
	logic [4:0]  mtype;
	logic [1:0]  rev;
	logic [2:0]  rid;
	logic [2:0]  ndo;
	logic        ext;
	logic [7:0]  len_m2, payload;
	logic        frame_ok, gc_frame, payload_ok;
	logic        accept;

	logic        rx_valid_s1;
	logic [23:0] ring_rdata;

	assign accept = in_valid && in_ready;
	assign in_ready = !out_valid || out_ready;

	assign mtype = header[4:0];
	assign rev = header[7:6];
	assign rid = header[11:9];
	assign ndo = header[14:12];
	assign ext = header[15];
	assign len_m2 = frame_len - pdgc_pkg::MIN_FRAME_BYTES;
	assign payload = ext ? len_m2 : {3'b000, ndo, 2'b00};
	assign gc_hdr = {4'b0000, rid, 1'b0, rev, 1'b0, pdgc_pkg::MSG_GOODCRC};
	assign frame_ok = (frame_len >= pdgc_pkg::MIN_FRAME_BYTES) && (frame_len <= max_frame_q);
	assign gc_frame = !ext && (ndo == 3'd0) && (mtype == pdgc_pkg::MSG_GOODCRC);
	assign payload_ok = (payload <= len_m2) && (payload <= max_payload_q);
	assign ring_next = (head_q == LAST) ? '0 : head_q + AW'(1);

	always_comb begin
		n_head = head_q;
		n_tail = tail_q;
		n_origin = origin_q;
		n_state = state_q;
		n_msg_id = msg_id_q;
		n_gc_pend = gc_pend_q;
		n_gc_pend_hdr = gc_pend_hdr_q;
		n_rx_en = rx_en_q;
		n_attached = attached_q;
		n_sink_ok = sink_ok_q;
		n_watch = watch_q;
		n_sink_cnt = sink_cnt_q;
		attempted = 1'b0;
		known = 1'b1;
		ring_we = 1'b0;
		ring_re = 1'b0;
		o_gc = 1'b0;
		o_gc_hdr = '0;
		o_data = 1'b0;
		o_hr = 1'b0;
		o_wake = 1'b0;
		o_rxv = 1'b0;
		o_notify = 1'b0;
		arm_hdr = gc_hdr;

		case (action)
			pdgc_pkg::ACT_RX_FRAME: begin
				if (frame_ok) begin
					if (gc_frame) begin
						if (n_origin == pdgc_pkg::ORG_DATA && n_state == pdgc_pkg::TX_SENDING &&
						    rid == n_msg_id) begin
							n_state = pdgc_pkg::TX_SUCCESS;
							n_origin = pdgc_pkg::ORG_NONE;
							n_sink_ok = 1'b0;
						end
						o_wake = 1'b1;
					end else if (sop_kind == 3'd0 && payload_ok) begin
						if (rx_en_q) begin
							if (ring_next == n_tail) begin
								n_tail = (n_tail == LAST) ? '0 : n_tail + AW'(1);
							end
							ring_we = 1'b1;
							n_head = ring_next;
							o_wake = 1'b1;
						end
						if (!wire_busy) begin
							if (n_origin != pdgc_pkg::ORG_NONE) begin
								n_gc_pend = 1'b1;
								n_gc_pend_hdr = gc_hdr;
							end else begin
								attempted = 1'b1;
								if (send_accepted) begin
									n_origin = pdgc_pkg::ORG_GOODCRC;
									n_gc_pend_hdr = gc_hdr;
									o_gc = 1'b1;
									o_gc_hdr = gc_hdr;
								end else begin
									n_gc_pend = 1'b1;
									n_gc_pend_hdr = gc_hdr;
								end
							end
						end else if (rx_en_q) begin
							n_gc_pend = 1'b1;
							n_gc_pend_hdr = gc_hdr;
						end
					end
				end
			end
			pdgc_pkg::ACT_TX_DONE: begin
				if (n_origin == pdgc_pkg::ORG_DATA) begin
					if (n_state == pdgc_pkg::TX_SENDING && status_fail) begin
						n_state = pdgc_pkg::TX_FAIL;
						n_origin = pdgc_pkg::ORG_NONE;
						n_sink_ok = 1'b0;
					end
				end else if (n_origin == pdgc_pkg::ORG_GOODCRC) begin
					n_origin = pdgc_pkg::ORG_NONE;
					if (status_fail) begin
						n_gc_pend = 1'b1;
					end
				end
				o_wake = 1'b1;
			end
			pdgc_pkg::ACT_HR_DONE: begin
				if (n_state == pdgc_pkg::TX_SENDING) begin
					n_state = pdgc_pkg::TX_SUCCESS;
				end
				n_origin = pdgc_pkg::ORG_NONE;
				o_wake = 1'b1;
			end
			pdgc_pkg::ACT_HR_RX: begin
				n_state = pdgc_pkg::TX_UNSET;
				n_origin = pdgc_pkg::ORG_NONE;
				n_gc_pend = 1'b0;
				n_gc_pend_hdr = '0;
				n_sink_ok = 1'b0;
				n_tail = n_head;
				o_notify = 1'b1;
				o_wake = 1'b1;
			end
			pdgc_pkg::ACT_TICK: begin
				if (n_watch != 8'd0) begin
					n_watch = n_watch - 8'd1;
				end
				if (n_sink_cnt != pdgc_pkg::COUNT_MAX) begin
					n_sink_cnt = n_sink_cnt + 8'd1;
				end
			end
			pdgc_pkg::ACT_TRANSMIT: begin
				n_msg_id = rid;
				n_state = pdgc_pkg::TX_ENQUEUED;
				o_wake = 1'b1;
			end
			pdgc_pkg::ACT_FETCH: begin
				if (n_tail != n_head) begin
					o_rxv = 1'b1;
					ring_re = 1'b1;
					n_tail = (n_tail == LAST) ? '0 : n_tail + AW'(1);
				end
			end
			pdgc_pkg::ACT_RX_ENABLE: begin
				n_rx_en = enable;
				if (!enable) begin
					n_tail = n_head;
					n_gc_pend = 1'b0;
					n_gc_pend_hdr = '0;
				end
				o_wake = 1'b1;
			end
			pdgc_pkg::ACT_ATTACH: begin
				if (!n_attached) begin
					n_attached = 1'b1;
					n_state = pdgc_pkg::TX_UNSET;
					n_origin = pdgc_pkg::ORG_NONE;
					n_gc_pend = 1'b0;
					n_gc_pend_hdr = '0;
					n_sink_ok = 1'b0;
					n_tail = n_head;
					n_rx_en = 1'b1;
				end
			end
			pdgc_pkg::ACT_DETACH: begin
				if (n_attached) begin
					n_attached = 1'b0;
					n_state = pdgc_pkg::TX_UNSET;
					n_origin = pdgc_pkg::ORG_NONE;
					n_gc_pend = 1'b0;
					n_gc_pend_hdr = '0;
					n_sink_ok = 1'b0;
					n_tail = n_head;
				end
			end
			pdgc_pkg::ACT_HR_SEND: begin
				attempted = 1'b1;
				if (send_accepted) begin
					o_hr = 1'b1;
					n_state = pdgc_pkg::TX_SENDING;
				end else begin
					n_state = pdgc_pkg::TX_FAIL;
				end
			end
			default: begin
				known = 1'b0;
			end
		endcase

		if (known) begin
			// A deferred GoodCRC is retried first, then the data frame is watched or started.
			if (n_gc_pend && n_state != pdgc_pkg::TX_SENDING && !wire_busy && !attempted) begin
				n_gc_pend = 1'b0;
				arm_hdr = n_gc_pend_hdr;
				if (n_origin != pdgc_pkg::ORG_NONE) begin
					n_gc_pend = 1'b1;
				end else begin
					attempted = 1'b1;
					if (send_accepted) begin
						n_origin = pdgc_pkg::ORG_GOODCRC;
						o_gc = 1'b1;
						o_gc_hdr = arm_hdr;
					end else begin
						n_gc_pend = 1'b1;
					end
				end
				o_wake = 1'b1;
			end
			if (n_state == pdgc_pkg::TX_SENDING && n_origin == pdgc_pkg::ORG_DATA) begin
				if (n_watch == 8'd0) begin
					n_state = pdgc_pkg::TX_FAIL;
					n_origin = pdgc_pkg::ORG_NONE;
					n_sink_ok = 1'b0;
					o_wake = 1'b1;
				end
			end else if (n_state == pdgc_pkg::TX_ENQUEUED && !wire_busy && !attempted) begin
				attempted = 1'b1;
				n_sink_cnt = 8'd0;
				if (send_accepted) begin
					n_origin = pdgc_pkg::ORG_DATA;
					n_sink_ok = 1'b1;
					n_state = pdgc_pkg::TX_SENDING;
					n_watch = tx_watch_q;
					o_data = 1'b1;
				end else begin
					n_origin = pdgc_pkg::ORG_NONE;
					n_sink_ok = 1'b0;
				end
				o_wake = 1'b1;
			end
			if (n_sink_ok && n_origin == pdgc_pkg::ORG_NONE && n_sink_cnt >= sink_idle_q) begin
				n_sink_ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_watch_q <= pdgc_pkg::RST_TX_WATCH;
			sink_idle_q <= pdgc_pkg::RST_SINK_OK_IDLE;
			max_frame_q <= pdgc_pkg::RST_MAX_FRAME;
			max_payload_q <= pdgc_pkg::RST_MAX_PAYLOAD;
		end else if (cfg_we) begin
			case (cfg_index)
				pdgc_pkg::CFG_TX_WATCH:     tx_watch_q <= cfg_data;
				pdgc_pkg::CFG_SINK_OK_IDLE: sink_idle_q <= cfg_data;
				pdgc_pkg::CFG_MAX_FRAME:    max_frame_q <= cfg_data;
				pdgc_pkg::CFG_MAX_PAYLOAD:  max_payload_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			origin_q <= pdgc_pkg::ORG_NONE;
			state_q <= pdgc_pkg::TX_UNSET;
			msg_id_q <= '0;
			gc_pend_q <= 1'b0;
			gc_pend_hdr_q <= '0;
			rx_en_q <= 1'b1;
			attached_q <= 1'b0;
			sink_ok_q <= 1'b0;
			watch_q <= '0;
			sink_cnt_q <= '0;
		end else if (accept) begin
			head_q <= n_head;
			tail_q <= n_tail;
			origin_q <= n_origin;
			state_q <= n_state;
			msg_id_q <= n_msg_id;
			gc_pend_q <= n_gc_pend;
			gc_pend_hdr_q <= n_gc_pend_hdr;
			rx_en_q <= n_rx_en;
			attached_q <= n_attached;
			sink_ok_q <= n_sink_ok;
			watch_q <= n_watch;
			sink_cnt_q <= n_sink_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			send_goodcrc <= o_gc;
			goodcrc_header <= o_gc_hdr;
			send_data <= o_data;
			send_hard_reset <= o_hr;
			tx_status <= n_state;
			sink_tx_ok <= n_sink_ok;
			rx_valid_s1 <= o_rxv;
			notify_hard_reset <= o_notify;
			wake <= o_wake;
		end
	end

	pdgc_ram #(
		.WIDTH(24),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (accept && ring_we),
		.waddr(head_q),
		.wdata({header, payload}),
		.re   (accept && ring_re),
		.raddr(tail_q),
		.rdata(ring_rdata)
	);

	assign rx_valid = rx_valid_s1;
	assign rx_header_out = rx_valid_s1 ? ring_rdata[23:8] : 16'd0;
	assign rx_len_out = rx_valid_s1 ? ring_rdata[7:0] : 8'd0;

endmodule

`default_nettype wire

/* src/pdgc_checker.sv */
// Port-level assertions for the PD GoodCRC and transmit resolver, bound to its top level.
`default_nettype none

module pdgc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        send_goodcrc,
	input wire logic [15:0] goodcrc_header,
	input wire logic        send_data,
	input wire logic        send_hard_reset,
	input wire logic [2:0]  tx_status,
	input wire logic        rx_valid,
	input wire logic [15:0] rx_header_out,
	input wire logic [7:0]  rx_len_out
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_status) && $stable(goodcrc_header))
		else $error("Result changed while stalled.");

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("Input ready does not follow the result register.");

	a_one_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({send_goodcrc, send_data, send_hard_reset}))
		else $error("More than one send started in one transaction.");

	a_data_sending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_data |-> tx_status == pdgc_pkg::TX_SENDING)
		else $error("Data frame started without the sending status.");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (send_goodcrc || goodcrc_header == 16'd0) &&
			(rx_valid || (rx_header_out == 16'd0 && rx_len_out == 8'd0)))
		else $error("Unused result field is not zero.");

endmodule

bind pd_goodcrc_tx_resolver pdgc_checker u_pdgc_checker (.*);

`default_nettype wire
